/* hw/rtl/tasa_pkg.sv */
// ----------------------------------------------------------------------------
// tasa_pkg: shared types and constants for the texture atlas shelf allocator
// Field widths, command and status codes, the payload structs of both
// channels and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tasa_pkg;

	localparam int DIM_W  = 14;
	localparam int ID_W   = 8;
	localparam int CNT_W  = 9;
	localparam int STAT_W = 3;
	localparam int CMD_W  = 2;
	localparam int SUM_W  = DIM_W + 1;

	localparam int NUM_IDS  = 256;
	localparam int BOUNDS_W = 4 * DIM_W;

	// freed-id search: groups of bits, group first, then bit within the group
	localparam int GRP_W     = 16;
	localparam int NUM_GRP   = NUM_IDS / GRP_W;
	localparam int GRP_IDX_W = 4;
	localparam int BIT_IDX_W = 4;

	// growth step floor(n*6/5): reciprocal of five scaled by 2^18
	localparam int X6_W        = DIM_W + 2;
	localparam int RECIP_W     = 16;
	localparam int PROD_W      = X6_W + RECIP_W;
	localparam int RECIP_SHIFT = 18;
	localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

	localparam logic [DIM_W-1:0] INITIAL_SIDE = 14'd32;
	localparam logic [DIM_W-1:0] SIDE_CAP     = 14'd8192;
	localparam logic [DIM_W-1:0] MAX_LEN_RST  = 14'd4096;
	localparam logic [DIM_W-1:0] FIELD_MAX    = 14'd16383;
	localparam logic [CNT_W-1:0] IDS_LIMIT    = 9'd256;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_IDS   = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_ID   = 3'd4;

	// which fields a result carries besides status and atlas size
	localparam logic [1:0] RES_NONE   = 2'd0;
	localparam logic [1:0] RES_TEXID  = 2'd1;
	localparam logic [1:0] RES_LOOKUP = 2'd2;
	localparam logic [1:0] RES_PLACE  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic [ID_W-1:0]  tex_id;
	} req_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   out_id;
		logic [DIM_W-1:0]  pos_x;
		logic [DIM_W-1:0]  pos_y;
		logic [DIM_W-1:0]  size_w;
		logic [DIM_W-1:0]  size_h;
		logic [DIM_W-1:0]  atlas_w;
		logic [DIM_W-1:0]  atlas_h;
	} rsp_item_t;

	typedef struct packed {
		logic              load_req;
		logic              grp_search;
		logic              bit_search;
		logic              row_new;
		logic              grow_load;
		logic              grow_step;
		logic              grow_commit;
		logic              place;
		logic              free_set;
		logic              ram_read;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
		logic [1:0]        res_src;
		logic              out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             size_bad;
		logic             issued;
		logic             tex_freed;
		logic             ids_full;
		logic             found;
		logic             row_change;
		logic             fits;
		logic             grow_busy;
		logic             out_free;
	} dp_sts_t;

endpackage

/* hw/rtl/tasa_ram.sv */
// ----------------------------------------------------------------------------
// tasa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tasa_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/tasa_dp.sv */
// ----------------------------------------------------------------------------
// tasa_dp: allocator datapath
// Packer state, freed-id bitmap and search, growth unit, bounds memory,
// result staging and output register.
// ----------------------------------------------------------------------------
module tasa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tasa_pkg::DIM_W-1:0]    cfg_wdata,
	input  tasa_pkg::req_item_t           req_item,
	output tasa_pkg::rsp_item_t           rsp_item,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  tasa_pkg::ctl_cmd_t            cmd,
	output tasa_pkg::dp_sts_t             sts
);

	import tasa_pkg::*;

	logic [DIM_W-1:0]   max_len_q;
	req_item_t          req_q;
	logic [DIM_W-1:0]   cursor_x_q;
	logic [DIM_W-1:0]   cursor_y_q;
	logic [DIM_W-1:0]   row_h_q;
	logic [DIM_W-1:0]   atlas_w_q;
	logic [DIM_W-1:0]   atlas_h_q;
	logic [CNT_W-1:0]   ids_q;
	logic [NUM_IDS-1:0] freed_q;
	logic [GRP_IDX_W-1:0] grp_q;
	logic               grp_found_q;
	logic [ID_W-1:0]    id_q;
	logic [DIM_W-1:0]   grow_w_q;
	logic [DIM_W-1:0]   grow_h_q;
	rsp_item_t          res_q;
	rsp_item_t          rsp_q;
	logic               rsp_valid_q;

	logic [DIM_W-1:0]     lim;
	logic [SUM_W-1:0]     sum_w;
	logic [SUM_W-1:0]     sum_h;
	logic [SUM_W-1:0]     cy_sum;
	logic                 need_w;
	logic                 need_h;
	logic [NUM_GRP-1:0]   grp_any;
	logic [GRP_IDX_W-1:0] grp_sel;
	logic [GRP_W-1:0]     grp_bits;
	logic [BIT_IDX_W-1:0] bit_sel;
	logic [ID_W-1:0]      new_id;
	logic [BOUNDS_W-1:0]  ram_wdata;
	logic [BOUNDS_W-1:0]  ram_rdata;
	rsp_item_t            res_next;

	// n -> floor(n*6/5), at least n+1
	function automatic logic [DIM_W-1:0] grow_step(input logic [DIM_W-1:0] n);
		logic [X6_W-1:0]   x6;
		logic [PROD_W-1:0] prod;
		logic [DIM_W-1:0]  s;
		x6   = (X6_W'(n) << 2) + (X6_W'(n) << 1);
		prod = PROD_W'(x6) * PROD_W'(RECIP_5);
		s    = prod[RECIP_SHIFT +: DIM_W];
		if (s <= n) begin
			s = n + DIM_W'(1);
		end
		return s;
	endfunction

	// effective side limit
	always_comb begin
		if (max_len_q < INITIAL_SIDE) begin
			lim = INITIAL_SIDE;
		end else if (max_len_q > SIDE_CAP) begin
			lim = SIDE_CAP;
		end else begin
			lim = max_len_q;
		end
	end

	assign sum_w  = SUM_W'(req_q.rect_width) + SUM_W'(cursor_x_q);
	assign sum_h  = SUM_W'(req_q.rect_height) + SUM_W'(cursor_y_q);
	assign cy_sum = SUM_W'(cursor_y_q) + SUM_W'(row_h_q);
	assign need_w = (sum_w < SUM_W'(lim)) && (sum_w > SUM_W'(grow_w_q));
	assign need_h = (sum_h < SUM_W'(lim)) && (sum_h > SUM_W'(grow_h_q));

	// lowest freed id: pick group, then bit
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_any[g] = |freed_q[g*GRP_W +: GRP_W];
		end
		grp_sel = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				grp_sel = GRP_IDX_W'(g);
			end
		end
		grp_bits = freed_q[grp_q*GRP_W +: GRP_W];
		bit_sel  = '0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = BIT_IDX_W'(b);
			end
		end
	end

	assign new_id    = grp_found_q ? id_q : ids_q[ID_W-1:0];
	assign ram_wdata = {cursor_x_q, cursor_y_q, req_q.rect_width, req_q.rect_height};

	tasa_ram #(
		.WIDTH (BOUNDS_W),
		.DEPTH (NUM_IDS)
	) u_bounds (
		.clk   (clk),
		.we    (cmd.place),
		.waddr (new_id),
		.wdata (ram_wdata),
		.re    (cmd.ram_read),
		.raddr (req_q.tex_id),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= MAX_LEN_RST;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			row_h_q    <= '0;
			atlas_w_q  <= INITIAL_SIDE;
			atlas_h_q  <= INITIAL_SIDE;
			ids_q      <= '0;
			freed_q    <= '0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (cmd.row_new) begin
				cursor_y_q <= (cy_sum > SUM_W'(FIELD_MAX)) ? FIELD_MAX : cy_sum[DIM_W-1:0];
				cursor_x_q <= '0;
				row_h_q    <= '0;
			end
			if (cmd.grow_commit) begin
				atlas_w_q <= (grow_w_q > lim) ? lim : grow_w_q;
				atlas_h_q <= (grow_h_q > lim) ? lim : grow_h_q;
			end
			if (cmd.free_set) begin
				freed_q[req_q.tex_id] <= 1'b1;
			end
			if (cmd.place) begin
				if (grp_found_q) begin
					freed_q[id_q] <= 1'b0;
				end else begin
					ids_q <= ids_q + CNT_W'(1);
				end
				if (req_q.rect_height > row_h_q) begin
					row_h_q <= req_q.rect_height;
				end
				cursor_x_q <= cursor_x_q + req_q.rect_width;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_item;
		end
		if (cmd.grp_search) begin
			grp_q       <= grp_sel;
			grp_found_q <= |grp_any;
		end
		if (cmd.bit_search) begin
			id_q <= {grp_q, bit_sel};
		end
		if (cmd.grow_load) begin
			grow_w_q <= atlas_w_q;
			grow_h_q <= atlas_h_q;
		end else if (cmd.grow_step) begin
			if (need_w) begin
				grow_w_q <= grow_step(grow_w_q);
			end
			if (need_h) begin
				grow_h_q <= grow_step(grow_h_q);
			end
		end
		if (cmd.res_load) begin
			res_q <= res_next;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		res_next         = '0;
		res_next.status  = cmd.res_status;
		res_next.atlas_w = atlas_w_q;
		res_next.atlas_h = atlas_h_q;
		case (cmd.res_src)
			RES_TEXID: begin
				res_next.out_id = req_q.tex_id;
			end
			RES_LOOKUP: begin
				res_next.out_id = req_q.tex_id;
				{res_next.pos_x, res_next.pos_y, res_next.size_w, res_next.size_h} = ram_rdata;
			end
			RES_PLACE: begin
				res_next.out_id = new_id;
				res_next.pos_x  = cursor_x_q;
				res_next.pos_y  = cursor_y_q;
				res_next.size_w = req_q.rect_width;
				res_next.size_h = req_q.rect_height;
			end
			default: begin
				res_next.out_id = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_item  = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts            = '0;
		sts.command    = req_q.command;
		sts.size_bad   = (req_q.rect_width > lim) || (req_q.rect_height > lim);
		sts.issued     = CNT_W'(req_q.tex_id) < ids_q;
		sts.tex_freed  = freed_q[req_q.tex_id];
		sts.ids_full   = ids_q == IDS_LIMIT;
		sts.found      = grp_found_q;
		sts.row_change = (atlas_w_q == lim) && (sum_w >= SUM_W'(lim));
		sts.fits       = (sum_w <= SUM_W'(atlas_w_q)) && (sum_h <= SUM_W'(atlas_h_q));
		sts.grow_busy  = need_w || need_h;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

endmodule

/* hw/rtl/tasa_ctrl.sv */
// ----------------------------------------------------------------------------
// tasa_ctrl: allocator controller
// Sequences one request at a time through decode, id search, row change,
// growth, placement and result hand-off.
// ----------------------------------------------------------------------------
module tasa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tasa_pkg::dp_sts_t   sts,
	output tasa_pkg::ctl_cmd_t  cmd
);

	import tasa_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_SRCH_GRP = 4'd2;
	localparam logic [3:0] S_SRCH_BIT = 4'd3;
	localparam logic [3:0] S_ROW      = 4'd4;
	localparam logic [3:0] S_CHK      = 4'd5;
	localparam logic [3:0] S_GROW     = 4'd6;
	localparam logic [3:0] S_FIT      = 4'd7;
	localparam logic [3:0] S_READ     = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.command)
					CMD_ALLOC: begin
						if (sts.size_bad) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_BAD_SIZE;
							cmd.res_src    = RES_NONE;
							state_d        = S_DONE;
						end else begin
							state_d = S_SRCH_GRP;
						end
					end
					CMD_FREE: begin
						cmd.res_load   = 1'b1;
						cmd.res_src    = RES_TEXID;
						cmd.free_set   = sts.issued;
						cmd.res_status = sts.issued ? ST_OK : ST_BAD_ID;
						state_d        = S_DONE;
					end
					CMD_LOOKUP: begin
						if (sts.issued && !sts.tex_freed) begin
							cmd.ram_read = 1'b1;
							state_d      = S_READ;
						end else begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_BAD_ID;
							cmd.res_src    = RES_TEXID;
							state_d        = S_DONE;
						end
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_OK;
						cmd.res_src    = RES_NONE;
						state_d        = S_DONE;
					end
				endcase
			end
			S_SRCH_GRP: begin
				cmd.grp_search = 1'b1;
				state_d        = S_SRCH_BIT;
			end
			S_SRCH_BIT: begin
				cmd.bit_search = 1'b1;
				state_d        = S_ROW;
			end
			S_ROW: begin
				if (sts.ids_full && !sts.found) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NO_IDS;
					cmd.res_src    = RES_NONE;
					state_d        = S_DONE;
				end else begin
					cmd.row_new = sts.row_change;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.fits) begin
					state_d = S_FIT;
				end else begin
					cmd.grow_load = 1'b1;
					state_d       = S_GROW;
				end
			end
			S_GROW: begin
				if (sts.grow_busy) begin
					cmd.grow_step = 1'b1;
				end else begin
					cmd.grow_commit = 1'b1;
					state_d         = S_FIT;
				end
			end
			S_FIT: begin
				cmd.res_load = 1'b1;
				if (sts.fits) begin
					cmd.place      = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_src    = RES_PLACE;
				end else begin
					cmd.res_status = ST_NO_SPACE;
					cmd.res_src    = RES_NONE;
				end
				state_d = S_DONE;
			end
			S_READ: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_src    = RES_LOOKUP;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/texture_atlas_shelf_allocator.sv */
// ----------------------------------------------------------------------------
// texture_atlas_shelf_allocator: shelf packer for a growing texture atlas
// Allocates rectangles row by row, reuses freed ids, grows the atlas in
// 6/5 steps up to max_length (clamped to 32..8192), and answers free and lookup requests.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_item  (command, size, id)
// rsp       out        rsp_valid / rsp_stall     rsp_item  (status, id, bounds, atlas)
// cfg       in         cfg_we                    cfg_wdata (max_length)
//
// One request at a time. When the atlas grows, it grows by 6/5 steps, one
// per cycle, at most 31.
// Reset: max_length 4096, atlas 32 x 32, cursor, ids and freed bitmap cleared;
// bounds memory is not cleared, only issued ids are read back.
// A stalled rsp holds the controller at hand-off only; the next request may
// transfer while the previous result waits in the output register.
//
module texture_atlas_shelf_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tasa_pkg::DIM_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  tasa_pkg::req_item_t        req_item,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tasa_pkg::rsp_item_t        rsp_item
);

	import tasa_pkg::*;

	// controller to datapath commands, datapath flags back
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	tasa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tasa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_item  (req_item),
		.rsp_item  (rsp_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* test/texture_atlas_shelf_allocator_tb.sv */
// ----------------------------------------------------------------------------
// texture_atlas_shelf_allocator_tb: self-checking bench for the shelf packer
// Drives allocate, free, lookup and unused commands through the req channel
// and checks every rsp transfer against a shelf-packing predictor kept in
// step with the block. Runs a directed table first, then random phases
// under several max_length settings, including identifier exhaustion.
// ----------------------------------------------------------------------------
module texture_atlas_shelf_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tasa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int WANT_DEPTH = 2048;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [DIM_W-1:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_item_t   req_item  = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp_item;

	// no idling on either side while set
	bit calm = 1'b0;
	int fail_count = 0;

	texture_atlas_shelf_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Shelf-packing predictor state
	// ------------------------------------------------------------------
	typedef struct {
		int unsigned x;
		int unsigned y;
		int unsigned w;
		int unsigned h;
	} bounds_t;

	logic [DIM_W-1:0] max_len_reg = MAX_LEN_RST;
	int unsigned cur_x  = 0;
	int unsigned cur_y  = 0;
	int unsigned row_h  = 0;
	int unsigned atl_w  = 32'(INITIAL_SIDE);
	int unsigned atl_h  = 32'(INITIAL_SIDE);
	int unsigned ids_used = 0;
	bit          id_freed [NUM_IDS];
	bounds_t     bounds_mem [NUM_IDS];

	// expected results in transfer order
	rsp_item_t want_fifo [WANT_DEPTH];
	int        want_wr = 0;
	int        want_rd = 0;

	// max_length as the packer sees it: clamped to [INITIAL_SIDE, SIDE_CAP]
	function automatic int unsigned side_limit();
		int unsigned m;
		m = 32'(max_len_reg);
		if (m < 32'(INITIAL_SIDE))
			m = 32'(INITIAL_SIDE);
		if (m > 32'(SIDE_CAP))
			m = 32'(SIDE_CAP);
		return m;
	endfunction

	// one side grows n -> floor(n*6/5), at least +1, until it covers need;
	// no growth when need is beyond the limit, result clamped to the limit
	function automatic int unsigned grow_side(int unsigned cur, int unsigned need,
	                                          int unsigned lim);
		int unsigned n;
		int unsigned s;
		n = cur;
		if (need < lim) begin
			while (need > n) begin
				s = (n * 6) / 5;
				if (s <= n)
					s = n + 1;
				n = s;
			end
		end
		if (n > lim)
			n = lim;
		return n;
	endfunction

	function automatic bit any_freed();
		for (int i = 0; i < NUM_IDS; i++)
			if (id_freed[i])
				return 1'b1;
		return 1'b0;
	endfunction

	// works out the answer to one request and moves the packer state on
	function automatic rsp_item_t shelf_predict(req_item_t r);
		rsp_item_t   e;
		int unsigned lim;
		int unsigned w;
		int unsigned h;
		int unsigned t;
		int unsigned slot;
		bit          reuse;
		bit          known;
		e = '0;
		w = 32'(r.rect_width);
		h = 32'(r.rect_height);
		t = 32'(r.tex_id);
		known = (t < ids_used);
		case (r.command)
			CMD_ALLOC: begin
				lim = side_limit();
				reuse = 1'b0;
				slot = 0;
				if (w > lim || h > lim) begin
					e.status = ST_BAD_SIZE;
				end else begin
					// lowest freed identifier first
					for (int i = 0; i < ids_used && !reuse; i++) begin
						if (id_freed[i]) begin
							slot = i;
							reuse = 1'b1;
						end
					end
					if (!reuse && ids_used >= NUM_IDS) begin
						e.status = ST_NO_IDS;
					end else begin
						// full-width atlas: start a new shelf below the tallest one
						if (atl_w == lim && w + cur_x >= lim) begin
							cur_y = (cur_y + row_h > 32'(FIELD_MAX)) ? 32'(FIELD_MAX)
							                                         : cur_y + row_h;
							cur_x = 0;
							row_h = 0;
						end
						if (w + cur_x > atl_w || h + cur_y > atl_h) begin
							atl_w = grow_side(atl_w, w + cur_x, lim);
							atl_h = grow_side(atl_h, h + cur_y, lim);
						end
						// failed fit keeps the shelf change and growth
						if (w + cur_x > atl_w || h + cur_y > atl_h) begin
							e.status = ST_NO_SPACE;
						end else begin
							if (reuse) begin
								id_freed[slot] = 1'b0;
							end else begin
								slot = ids_used;
								ids_used++;
							end
							bounds_mem[slot] = '{cur_x, cur_y, w, h};
							if (h > row_h)
								row_h = h;
							e.status = ST_OK;
							e.out_id = ID_W'(slot);
							e.pos_x  = DIM_W'(cur_x);
							e.pos_y  = DIM_W'(cur_y);
							e.size_w = DIM_W'(w);
							e.size_h = DIM_W'(h);
							cur_x += w;
						end
					end
				end
			end
			CMD_FREE: begin
				e.out_id = ID_W'(t);
				if (known) begin
					id_freed[t] = 1'b1;
					e.status = ST_OK;
				end else begin
					e.status = ST_BAD_ID;
				end
			end
			CMD_LOOKUP: begin
				e.out_id = ID_W'(t);
				if (known && !id_freed[t]) begin
					e.status = ST_OK;
					e.pos_x  = DIM_W'(bounds_mem[t].x);
					e.pos_y  = DIM_W'(bounds_mem[t].y);
					e.size_w = DIM_W'(bounds_mem[t].w);
					e.size_h = DIM_W'(bounds_mem[t].h);
				end else begin
					e.status = ST_BAD_ID;
				end
			end
			default: begin
				e.status = ST_OK;
			end
		endcase
		e.atlas_w = DIM_W'(atl_w);
		e.atlas_h = DIM_W'(atl_h);
		return e;
	endfunction

	// mostly a live identifier, now and then any value
	function automatic logic [ID_W-1:0] pick_id();
		if (ids_used != 0 && $urandom_range(6) != 0)
			return ID_W'($urandom_range(ids_used - 1));
		return ID_W'($urandom);
	endfunction

	// random request weighted towards small allocations on live state
	function automatic req_item_t random_request();
		req_item_t   r;
		int unsigned lim;
		int unsigned pick;
		int unsigned shape;
		lim = side_limit();
		r.rect_width  = DIM_W'($urandom);
		r.rect_height = DIM_W'($urandom);
		r.tex_id      = ID_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 55) begin
			r.command = CMD_ALLOC;
			shape = $urandom_range(9);
			if (shape < 7) begin
				r.rect_width  = DIM_W'($urandom_range(48));
				r.rect_height = DIM_W'($urandom_range(48));
			end else if (shape == 7) begin
				r.rect_width  = DIM_W'($urandom_range(lim));
				r.rect_height = DIM_W'($urandom_range(lim));
			end else if (shape == 8) begin
				r.rect_width  = DIM_W'($urandom_range(1) ? lim : 0);
				r.rect_height = DIM_W'($urandom_range(1) ? lim : 0);
			end
			// shape 9: full-range sizes, mostly invalid
		end else if (pick < 72) begin
			r.command = CMD_FREE;
			r.tex_id  = pick_id();
		end else if (pick < 92) begin
			r.command = CMD_LOOKUP;
			r.tex_id  = pick_id();
		end else begin
			r.command = CMD_UNUSED;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table: expectations typed in only where obvious
	// ------------------------------------------------------------------
	typedef struct {
		req_item_t req;
		bit        typed;
		rsp_item_t want;
	} stim_row_t;

	localparam int N_DIRECTED = 23;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// reset state: nothing issued, 32 x 32 atlas
		'{'{CMD_LOOKUP, 0, 0, 0},         1'b1, '{ST_BAD_ID, 0, 0, 0, 0, 0, 32, 32}},
		'{'{CMD_FREE, 0, 0, 255},         1'b1, '{ST_BAD_ID, 255, 0, 0, 0, 0, 32, 32}},
		'{'{CMD_ALLOC, 4097, 1, 0},       1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 32, 32}},
		'{'{CMD_ALLOC, 1, 8192, 0},       1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 32, 32}},
		'{'{CMD_ALLOC, 16383, 16383, 255}, 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 32, 32}},
		// zero-size rectangle placed normally
		'{'{CMD_ALLOC, 0, 0, 0},          1'b1, '{ST_OK, 0, 0, 0, 0, 0, 32, 32}},
		'{'{CMD_ALLOC, 16, 20, 0},        1'b0, '0},
		// forces growth on both sides
		'{'{CMD_ALLOC, 100, 50, 0},       1'b0, '0},
		'{'{CMD_LOOKUP, 0, 0, 1},         1'b0, '0},
		'{'{CMD_LOOKUP, 0, 0, 2},         1'b0, '0},
		// double free still answers ok
		'{'{CMD_FREE, 0, 0, 0},           1'b0, '0},
		'{'{CMD_FREE, 0, 0, 0},           1'b0, '0},
		'{'{CMD_LOOKUP, 0, 0, 0},         1'b0, '0},
		// reuses the freed identifier
		'{'{CMD_ALLOC, 3, 3, 0},          1'b0, '0},
		'{'{CMD_UNUSED, 16383, 16383, 255}, 1'b0, '0},
		// size at the limit that cannot fit: no space, no id taken
		'{'{CMD_ALLOC, 4096, 4096, 0},    1'b0, '0},
		'{'{CMD_ALLOC, 3000, 10, 0},      1'b0, '0},
		'{'{CMD_ALLOC, 4000, 8, 0},       1'b0, '0},
		// atlas not at full width, too narrow and unable to grow: no space
		'{'{CMD_ALLOC, 1000, 30, 0},      1'b0, '0},
		'{'{CMD_FREE, 0, 0, 200},         1'b0, '0},
		'{'{CMD_LOOKUP, 0, 0, 255},       1'b0, '0},
		'{'{CMD_FREE, 0, 0, 1},           1'b0, '0},
		'{'{CMD_ALLOC, 1, 1, 0},          1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Sender side; every task starts and ends at a falling edge
	// ------------------------------------------------------------------
	task automatic send_request(input req_item_t r, input bit typed, input rsp_item_t want);
		rsp_item_t pred;
		while (!calm && $urandom_range(99) < 36) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= r;
		do
			@(posedge clk);
		while (req_stall);
		// transfer taken at this edge
		pred = shelf_predict(r);
		want_fifo[want_wr] = typed ? want : pred;
		want_wr++;
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			send_request(random_request(), 1'b0, '0);
	endtask

	// hold the sender until every expected result has come back
	task automatic drain();
		req_valid <= 1'b0;
		while (want_wr != want_rd)
			@(negedge clk);
	endtask

	task automatic set_max_length(input logic [DIM_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		max_len_reg = v;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random stall, checked at the rising edge
	// ------------------------------------------------------------------
	always @(negedge clk)
		rsp_stall <= !calm && ($urandom_range(99) < 36);

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_wr == want_rd) begin
				$error("result transfer with nothing expected: %p", rsp_item);
				fail_count++;
			end else begin
				want = want_fifo[want_rd];
				want_rd++;
				if (rsp_item.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, rsp_item.status);
					fail_count++;
				end
				if (rsp_item.out_id !== want.out_id) begin
					$error("out_id expected %0d got %0d", want.out_id, rsp_item.out_id);
					fail_count++;
				end
				if (rsp_item.pos_x !== want.pos_x) begin
					$error("pos_x expected %0d got %0d", want.pos_x, rsp_item.pos_x);
					fail_count++;
				end
				if (rsp_item.pos_y !== want.pos_y) begin
					$error("pos_y expected %0d got %0d", want.pos_y, rsp_item.pos_y);
					fail_count++;
				end
				if (rsp_item.size_w !== want.size_w) begin
					$error("size_w expected %0d got %0d", want.size_w, rsp_item.size_w);
					fail_count++;
				end
				if (rsp_item.size_h !== want.size_h) begin
					$error("size_h expected %0d got %0d", want.size_h, rsp_item.size_h);
					fail_count++;
				end
				if (rsp_item.atlas_w !== want.atlas_w) begin
					$error("atlas_w expected %0d got %0d", want.atlas_w, rsp_item.atlas_w);
					fail_count++;
				end
				if (rsp_item.atlas_h !== want.atlas_h) begin
					$error("atlas_h expected %0d got %0d", want.atlas_h, rsp_item.atlas_h);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int fill_count;
		req_item_t r;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset value written explicitly, then the directed table
		set_max_length(MAX_LEN_RST);
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		run_random(100);

		// smallest legal side: atlas clamps down, many failed fits
		drain();
		set_max_length(14'd32);
		run_random(50);

		// largest side, no idling on either channel
		drain();
		set_max_length(SIDE_CAP);
		calm = 1'b1;
		run_random(80);
		calm = 1'b0;

		// below the legal range: acts as the smallest side
		drain();
		set_max_length(14'd0);
		run_random(30);

		// all ones: acts as the largest side; use up every identifier
		drain();
		set_max_length(FIELD_MAX);
		fill_count = 0;
		while (!(ids_used >= NUM_IDS && !any_freed()) && fill_count < 400) begin
			r = '0;
			r.command = CMD_ALLOC;
			r.tex_id  = ID_W'($urandom);
			send_request(r, 1'b0, '0);
			fill_count++;
		end
		// out of identifiers now
		for (int i = 0; i < 4; i++) begin
			r = '0;
			r.command     = CMD_ALLOC;
			r.rect_width  = DIM_W'($urandom_range(8));
			r.rect_height = DIM_W'($urandom_range(8));
			send_request(r, 1'b0, '0);
		end
		run_random(60);

		// lowered limit shrinks the atlas on the next growth
		drain();
		set_max_length(14'd100);
		run_random(40);

		drain();
		set_max_length(14'd5000);
		run_random(40);

		drain();
		repeat (64) @(posedge clk);
		if (fail_count == 0 && want_wr == want_rd) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit: far above the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/tasa_pkg.sv
hw/rtl/tasa_ram.sv
hw/rtl/tasa_dp.sv
hw/rtl/tasa_ctrl.sv
hw/rtl/texture_atlas_shelf_allocator.sv
test/texture_atlas_shelf_allocator_tb.sv
